// File: sv/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-256 CBC package
// Shared types, constants, the byte substitution function, xtime and sub_word.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned RoundCount = 14;
  localparam int unsigned RkWords = 60;

  typedef enum logic [2:0] {
    CFG_KEY0 = 3'd0,
    CFG_KEY1 = 3'd1,
    CFG_KEY2 = 3'd2,
    CFG_KEY3 = 3'd3,
    CFG_IV_HI = 3'd4,
    CFG_IV_LO = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } core_state_t;

  // Key expansion request and status between the top level and the scheduler.
  typedef struct packed {
    logic start;
    logic busy;
  } ks_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r = 8'h63; 8'h01: r = 8'h7C; 8'h02: r = 8'h77; 8'h03: r = 8'h7B;
      8'h04: r = 8'hF2; 8'h05: r = 8'h6B; 8'h06: r = 8'h6F; 8'h07: r = 8'hC5;
      8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0A: r = 8'h67; 8'h0B: r = 8'h2B;
      8'h0C: r = 8'hFE; 8'h0D: r = 8'hD7; 8'h0E: r = 8'hAB; 8'h0F: r = 8'h76;
      8'h10: r = 8'hCA; 8'h11: r = 8'h82; 8'h12: r = 8'hC9; 8'h13: r = 8'h7D;
      8'h14: r = 8'hFA; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hF0;
      8'h18: r = 8'hAD; 8'h19: r = 8'hD4; 8'h1A: r = 8'hA2; 8'h1B: r = 8'hAF;
      8'h1C: r = 8'h9C; 8'h1D: r = 8'hA4; 8'h1E: r = 8'h72; 8'h1F: r = 8'hC0;
      8'h20: r = 8'hB7; 8'h21: r = 8'hFD; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
      8'h24: r = 8'h36; 8'h25: r = 8'h3F; 8'h26: r = 8'hF7; 8'h27: r = 8'hCC;
      8'h28: r = 8'h34; 8'h29: r = 8'hA5; 8'h2A: r = 8'hE5; 8'h2B: r = 8'hF1;
      8'h2C: r = 8'h71; 8'h2D: r = 8'hD8; 8'h2E: r = 8'h31; 8'h2F: r = 8'h15;
      8'h30: r = 8'h04; 8'h31: r = 8'hC7; 8'h32: r = 8'h23; 8'h33: r = 8'hC3;
      8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9A;
      8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3A: r = 8'h80; 8'h3B: r = 8'hE2;
      8'h3C: r = 8'hEB; 8'h3D: r = 8'h27; 8'h3E: r = 8'hB2; 8'h3F: r = 8'h75;
      8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2C; 8'h43: r = 8'h1A;
      8'h44: r = 8'h1B; 8'h45: r = 8'h6E; 8'h46: r = 8'h5A; 8'h47: r = 8'hA0;
      8'h48: r = 8'h52; 8'h49: r = 8'h3B; 8'h4A: r = 8'hD6; 8'h4B: r = 8'hB3;
      8'h4C: r = 8'h29; 8'h4D: r = 8'hE3; 8'h4E: r = 8'h2F; 8'h4F: r = 8'h84;
      8'h50: r = 8'h53; 8'h51: r = 8'hD1; 8'h52: r = 8'h00; 8'h53: r = 8'hED;
      8'h54: r = 8'h20; 8'h55: r = 8'hFC; 8'h56: r = 8'hB1; 8'h57: r = 8'h5B;
      8'h58: r = 8'h6A; 8'h59: r = 8'hCB; 8'h5A: r = 8'hBE; 8'h5B: r = 8'h39;
      8'h5C: r = 8'h4A; 8'h5D: r = 8'h4C; 8'h5E: r = 8'h58; 8'h5F: r = 8'hCF;
      8'h60: r = 8'hD0; 8'h61: r = 8'hEF; 8'h62: r = 8'hAA; 8'h63: r = 8'hFB;
      8'h64: r = 8'h43; 8'h65: r = 8'h4D; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
      8'h68: r = 8'h45; 8'h69: r = 8'hF9; 8'h6A: r = 8'h02; 8'h6B: r = 8'h7F;
      8'h6C: r = 8'h50; 8'h6D: r = 8'h3C; 8'h6E: r = 8'h9F; 8'h6F: r = 8'hA8;
      8'h70: r = 8'h51; 8'h71: r = 8'hA3; 8'h72: r = 8'h40; 8'h73: r = 8'h8F;
      8'h74: r = 8'h92; 8'h75: r = 8'h9D; 8'h76: r = 8'h38; 8'h77: r = 8'hF5;
      8'h78: r = 8'hBC; 8'h79: r = 8'hB6; 8'h7A: r = 8'hDA; 8'h7B: r = 8'h21;
      8'h7C: r = 8'h10; 8'h7D: r = 8'hFF; 8'h7E: r = 8'hF3; 8'h7F: r = 8'hD2;
      8'h80: r = 8'hCD; 8'h81: r = 8'h0C; 8'h82: r = 8'h13; 8'h83: r = 8'hEC;
      8'h84: r = 8'h5F; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
      8'h88: r = 8'hC4; 8'h89: r = 8'hA7; 8'h8A: r = 8'h7E; 8'h8B: r = 8'h3D;
      8'h8C: r = 8'h64; 8'h8D: r = 8'h5D; 8'h8E: r = 8'h19; 8'h8F: r = 8'h73;
      8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4F; 8'h93: r = 8'hDC;
      8'h94: r = 8'h22; 8'h95: r = 8'h2A; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
      8'h98: r = 8'h46; 8'h99: r = 8'hEE; 8'h9A: r = 8'hB8; 8'h9B: r = 8'h14;
      8'h9C: r = 8'hDE; 8'h9D: r = 8'h5E; 8'h9E: r = 8'h0B; 8'h9F: r = 8'hDB;
      8'hA0: r = 8'hE0; 8'hA1: r = 8'h32; 8'hA2: r = 8'h3A; 8'hA3: r = 8'h0A;
      8'hA4: r = 8'h49; 8'hA5: r = 8'h06; 8'hA6: r = 8'h24; 8'hA7: r = 8'h5C;
      8'hA8: r = 8'hC2; 8'hA9: r = 8'hD3; 8'hAA: r = 8'hAC; 8'hAB: r = 8'h62;
      8'hAC: r = 8'h91; 8'hAD: r = 8'h95; 8'hAE: r = 8'hE4; 8'hAF: r = 8'h79;
      8'hB0: r = 8'hE7; 8'hB1: r = 8'hC8; 8'hB2: r = 8'h37; 8'hB3: r = 8'h6D;
      8'hB4: r = 8'h8D; 8'hB5: r = 8'hD5; 8'hB6: r = 8'h4E; 8'hB7: r = 8'hA9;
      8'hB8: r = 8'h6C; 8'hB9: r = 8'h56; 8'hBA: r = 8'hF4; 8'hBB: r = 8'hEA;
      8'hBC: r = 8'h65; 8'hBD: r = 8'h7A; 8'hBE: r = 8'hAE; 8'hBF: r = 8'h08;
      8'hC0: r = 8'hBA; 8'hC1: r = 8'h78; 8'hC2: r = 8'h25; 8'hC3: r = 8'h2E;
      8'hC4: r = 8'h1C; 8'hC5: r = 8'hA6; 8'hC6: r = 8'hB4; 8'hC7: r = 8'hC6;
      8'hC8: r = 8'hE8; 8'hC9: r = 8'hDD; 8'hCA: r = 8'h74; 8'hCB: r = 8'h1F;
      8'hCC: r = 8'h4B; 8'hCD: r = 8'hBD; 8'hCE: r = 8'h8B; 8'hCF: r = 8'h8A;
      8'hD0: r = 8'h70; 8'hD1: r = 8'h3E; 8'hD2: r = 8'hB5; 8'hD3: r = 8'h66;
      8'hD4: r = 8'h48; 8'hD5: r = 8'h03; 8'hD6: r = 8'hF6; 8'hD7: r = 8'h0E;
      8'hD8: r = 8'h61; 8'hD9: r = 8'h35; 8'hDA: r = 8'h57; 8'hDB: r = 8'hB9;
      8'hDC: r = 8'h86; 8'hDD: r = 8'hC1; 8'hDE: r = 8'h1D; 8'hDF: r = 8'h9E;
      8'hE0: r = 8'hE1; 8'hE1: r = 8'hF8; 8'hE2: r = 8'h98; 8'hE3: r = 8'h11;
      8'hE4: r = 8'h69; 8'hE5: r = 8'hD9; 8'hE6: r = 8'h8E; 8'hE7: r = 8'h94;
      8'hE8: r = 8'h9B; 8'hE9: r = 8'h1E; 8'hEA: r = 8'h87; 8'hEB: r = 8'hE9;
      8'hEC: r = 8'hCE; 8'hED: r = 8'h55; 8'hEE: r = 8'h28; 8'hEF: r = 8'hDF;
      8'hF0: r = 8'h8C; 8'hF1: r = 8'hA1; 8'hF2: r = 8'h89; 8'hF3: r = 8'h0D;
      8'hF4: r = 8'hBF; 8'hF5: r = 8'hE6; 8'hF6: r = 8'h42; 8'hF7: r = 8'h68;
      8'hF8: r = 8'h41; 8'hF9: r = 8'h99; 8'hFA: r = 8'h2D; 8'hFB: r = 8'h0F;
      8'hFC: r = 8'hB0; 8'hFD: r = 8'h54; 8'hFE: r = 8'hBB; 8'hFF: r = 8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

// File: sv/aes256_cbc_encrypt_unit.sv
// ----------------------------------------------------------------------------
// AES-256 CBC encryption unit
// Iterative AES-256 engine with CBC chaining and an on-chip round-key store.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         in_valid/in_stall   plain_high, plain_low, message_start
//  output    out        out_valid/out_stall cipher_high, cipher_low
//  config    in         cfg_wr_en           cfg_index, cfg_data
//
// The first round key is read at the edge that takes a request and added in the next
// cycle; the rounds of the shared round unit follow, and the last round's result is
// registered into the output register. No new request is taken until the block has
// left the core. A key register write stalls requests while the scheduler loads the
// key and expands it. The result waits in the output register while out_stall is high;
// a block finishing meanwhile waits in the core. Reset is synchronous.
module aes256_cbc_encrypt_unit import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] plain_high,
  input  logic [63:0] plain_low,
  input  logic        message_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low
);

  logic [255:0] key;
  logic [127:0] iv;
  logic [127:0] chain;
  logic [127:0] st;
  logic [127:0] st_next;
  logic [3:0]   round;
  logic [3:0]   round_next;
  logic [3:0]   rd_addr;
  logic [127:0] rk;
  logic [127:0] round_out;
  logic         in_accept;
  logic         ks_start;
  core_state_t  state;
  core_state_t  state_next;
  ks_ctrl_t     ks_in;
  ks_ctrl_t     ks_out;
  logic         rk_wr_en;
  logic [3:0]   rk_wr_addr;
  logic [127:0] rk_wr_data;
  logic         out_full;
  logic [127:0] out_data;
  logic         out_load;
  logic [127:0] out_load_data;
  logic         out_free;

  assign ks_start = cfg_wr_en && (cfg_index == CFG_KEY0 || cfg_index == CFG_KEY1 ||
                    cfg_index == CFG_KEY2 || cfg_index == CFG_KEY3);

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      iv  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY0:  key[255:192] <= cfg_data;
        CFG_KEY1:  key[191:128] <= cfg_data;
        CFG_KEY2:  key[127:64]  <= cfg_data;
        CFG_KEY3:  key[63:0]    <= cfg_data;
        CFG_IV_HI: iv[127:64]   <= cfg_data;
        CFG_IV_LO: iv[63:0]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The scheduler loads the key in the cycle after the write, once it has settled.
  logic ks_pend;
  always_ff @(posedge clk) begin
    if (rst) begin
      ks_pend <= 1'b0;
    end else begin
      ks_pend <= ks_start;
    end
  end

  // The window holds w[i-8] in entry 7, so word 0 of the key goes there.
  logic [255:0] key_rev;
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      key_rev[32*k +: 32] = key[32*k +: 32];
    end
  end

  assign ks_in.start = ks_pend;
  assign ks_in.busy  = 1'b0;

  aes_key_sched u_sched (
    .clk      (clk),
    .rst      (rst),
    .key      (key_rev),
    .ctrl_in  (ks_in),
    .ctrl_out (ks_out),
    .wr_en    (rk_wr_en),
    .wr_addr  (rk_wr_addr),
    .wr_data  (rk_wr_data)
  );

  aes_ram #(.Width(128), .Depth(16)) u_rk_ram (
    .clk     (clk),
    .wr_en   (rk_wr_en),
    .wr_addr (rk_wr_addr),
    .wr_data (rk_wr_data),
    .rd_addr (rd_addr),
    .rd_data (rk)
  );

  aes_round u_round (
    .state_in  (st),
    .rkey      (rk),
    .last      (round == 4'(RoundCount)),
    .state_out (round_out)
  );

  assign in_stall  = (state != ST_IDLE) || ks_out.busy || ks_pend;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_full || !out_stall;
  assign out_valid = out_full;
  assign cipher_high = out_data[127:64];
  assign cipher_low  = out_data[63:0];

  // Round 0 adds the first round key to the chained block; rounds 1..14 apply the round unit with
  // the key read in the previous cycle. The key store address leads by one.
  always_comb begin
    state_next    = state;
    round_next    = round;
    st_next       = st;
    rd_addr       = 4'd0;
    out_load      = 1'b0;
    out_load_data = st;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          st_next    = {plain_high, plain_low} ^ (message_start ? iv : chain);
          round_next = 4'd0;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        rd_addr    = round + 4'd1;
        round_next = round + 4'd1;
        if (round == 4'd0) begin
          st_next = st ^ rk;
        end else begin
          st_next = round_out;
        end
        if (round == 4'(RoundCount)) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_load_data = round_out;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      round    <= '0;
      chain    <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      round <= round_next;
      if (state == ST_ROUND && round == 4'(RoundCount)) begin
        chain <= round_out;
      end
      if (out_load) begin
        out_full <= 1'b1;
      end else if (!out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    st <= st_next;
    if (out_load) begin
      out_data <= out_load_data;
    end
  end

  a_out_after_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round == 4'(RoundCount)) |=> out_valid)
    else $error("result not presented after the last round");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable({cipher_high, cipher_low})))
    else $error("stalled result changed or dropped");

  a_no_req_in_expand: assert property (@(posedge clk) disable iff (rst)
    ks_out.busy |-> in_stall)
    else $error("request taken during key expansion");

endmodule

// File: sv/aes_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/aes_key_sched.sv
// ----------------------------------------------------------------------------
// AES-256 key scheduler
// Expands the 256-bit key into 60 words, one word per cycle, and writes
// them as 15 round keys of 128 bits.
// ----------------------------------------------------------------------------
module aes_key_sched import aes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [255:0] key,
  input  ks_ctrl_t     ctrl_in,
  output ks_ctrl_t     ctrl_out,
  output logic         wr_en,
  output logic [3:0]   wr_addr,
  output logic [127:0] wr_data
);

  // Sliding window of the last eight words, w[i-8] in win[7].
  logic [31:0] win [8];
  logic [5:0]  idx;
  logic [7:0]  rcon;
  logic        busy;
  logic [31:0] rk_buf [3];
  logic [31:0] temp;
  logic [31:0] new_word;

  always_comb begin
    temp = win[0];
    if (idx[2:0] == 3'd0) begin
      temp = sub_word({temp[23:0], temp[31:24]}) ^ {rcon, 24'h0};
    end else if (idx[2:0] == 3'd4) begin
      temp = sub_word(temp);
    end
    new_word = win[7] ^ temp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (ctrl_in.start) begin
      busy <= 1'b1;
      idx  <= 6'd0;
      rcon <= 8'h01;
      for (int k = 0; k < 8; k++) begin
        win[k] <= key[32*k +: 32];
      end
    end else if (busy) begin
      idx <= idx + 6'd1;
      if (idx >= 6'd8) begin
        for (int k = 7; k > 0; k--) begin
          win[k] <= win[k-1];
        end
        win[0] <= new_word;
        if (idx[2:0] == 3'd0) begin
          rcon <= xtime(rcon);
        end
      end
      if (idx == 6'(RkWords - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // The key words come out first straight from the window, then the new ones.
  logic [31:0] cur_word;
  always_comb begin
    cur_word = (idx < 6'd8) ? win[3'd7 - idx[2:0]] : new_word;
  end

  always_ff @(posedge clk) begin
    if (busy && idx[1:0] != 2'd3) begin
      rk_buf[idx[1:0]] <= cur_word;
    end
  end

  assign wr_en   = busy && (idx[1:0] == 2'd3);
  assign wr_addr = idx[5:2];
  assign wr_data = {rk_buf[0], rk_buf[1], rk_buf[2], cur_word};
  assign ctrl_out.start = 1'b0;
  assign ctrl_out.busy  = busy;

endmodule

// File: sv/aes_round.sv
// ----------------------------------------------------------------------------
// AES round unit
// One encryption round per cycle: SubBytes, ShiftRows, optional MixColumns,
// then the round key add.
// ----------------------------------------------------------------------------
module aes_round import aes_pkg::*; (
  input  logic [127:0] state_in,
  input  logic [127:0] rkey,
  input  logic         last,
  output logic [127:0] state_out
);

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      s[k] = state_in[127 - 8*k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c + r] = sbox(s[4*((c + r) % 4) + r]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] sum;
      sum = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ sum ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ sum ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ sum ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ sum ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int k = 0; k < 16; k++) begin
      state_out[127 - 8*k -: 8] = (last ? t[k] : m[k]) ^ rkey[127 - 8*k -: 8];
    end
  end

endmodule
